### hw/rtl/afr_pkg.sv
package afr_pkg;

	localparam logic [7:0]  DIGIT_BASE  = 8'h30;
	localparam logic [7:0]  RESET_NODE  = 8'h31;
	localparam logic [15:0] RESET_DELAY = 16'd3;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_MUTE = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDRESS   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_DELAY = 1'd1;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [5:0] byte_index;
		logic       last;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_ADDRESS = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_DATA    = 4'b0100,
		PH_CHECK   = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		REL_IDLE = 2'b01,
		REL_SEND = 2'b10
	} rel_state_t;

endpackage

### hw/rtl/addressed_frame_receiver.sv
// Channel  | Valid         | Stall          | Payload
// ---------+---------------+----------------+-----------------------------
// input    | item_valid    | item_stall     | item   (command, rx_byte)
// output   | result_valid  | result_stall   | result (kind, payload_byte, byte_index, last)
// config   | cfg_we        | -              | cfg_index, cfg_data
//
// A received byte or a tick is taken when item_valid is high and the input
// does not stall. A releasing tick starts a readout of the payload memory,
// one byte per cycle while the output does not stall, through the single
// read port; the input stalls until the last byte has left the read stage.
// Reset clears control state only; the payload memory holds no reset value.
// A stalled output holds its result and stalls the input.
module addressed_frame_receiver #(
	parameter int unsigned PAYLOAD_DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  afr_pkg::in_item_t                       item,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output afr_pkg::out_item_t                      result,
	input  logic                                    cfg_we,
	input  logic [afr_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [afr_pkg::CFG_DATA_W-1:0]          cfg_data
);

	localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [5:0] DEPTH6 = 6'(PAYLOAD_DEPTH);

	logic [7:0]          node_address_q;
	logic [15:0]         response_delay_q;
	afr_pkg::phase_t     phase_q;
	logic [5:0]          write_position_q;
	logic [7:0]          bytes_remaining_q;
	logic [5:0]          payload_count_q;
	logic                frame_pending_q;
	logic [15:0]         delay_left_q;
	afr_pkg::rel_state_t rel_state_q;
	logic [5:0]          rd_index_q;

	logic [7:0]          mem [PAYLOAD_DEPTH];
	logic [7:0]          rd_data_s1;
	logic [5:0]          rd_index_s1;
	logic                rd_last_s1;
	logic                rd_valid_s1;

	logic                out_valid_q;
	afr_pkg::out_item_t  out_data_q;

	logic                accept;
	logic                is_byte;
	logic                is_tick;
	logic                out_free;
	logic                issue;
	logic                mem_we;
	logic                mute_fire;
	logic [7:0]          br_dec;
	logic [15:0]         dl_dec;
	logic                rd_last;

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = (rel_state_q != afr_pkg::REL_IDLE) || rd_valid_s1
		|| (out_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;
	assign is_byte    = accept && (item.command == afr_pkg::CMD_BYTE) && !frame_pending_q;
	assign is_tick    = accept && (item.command == afr_pkg::CMD_TICK) && frame_pending_q;

	assign mute_fire  = is_byte && (phase_q == afr_pkg::PH_ADDRESS)
		&& (item.rx_byte != node_address_q);
	assign mem_we     = is_byte && (phase_q == afr_pkg::PH_DATA)
		&& (write_position_q < DEPTH6);
	assign br_dec     = bytes_remaining_q - {7'd0, bytes_remaining_q != 8'd0};
	assign dl_dec     = delay_left_q - {15'd0, delay_left_q != 16'd0};

	// the read stage refills whenever it is empty or its current byte moves to the output
	assign issue      = (rel_state_q == afr_pkg::REL_SEND) && (!rd_valid_s1 || out_free);
	assign rd_last    = (rd_index_q + 6'd1) == payload_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q   <= afr_pkg::RESET_NODE;
			response_delay_q <= afr_pkg::RESET_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				afr_pkg::CFG_NODE_ADDRESS:   node_address_q   <= cfg_data[7:0];
				afr_pkg::CFG_RESPONSE_DELAY: response_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= afr_pkg::PH_ADDRESS;
			write_position_q  <= 6'd0;
			bytes_remaining_q <= 8'd0;
			payload_count_q   <= 6'd0;
			frame_pending_q   <= 1'b0;
			delay_left_q      <= 16'd0;
			rel_state_q       <= afr_pkg::REL_IDLE;
			rd_index_q        <= 6'd0;
		end else begin
			if (is_byte) begin
				case (phase_q)
					afr_pkg::PH_ADDRESS: begin
						if (item.rx_byte == node_address_q)
							phase_q <= afr_pkg::PH_LENGTH;
					end
					afr_pkg::PH_LENGTH: begin
						bytes_remaining_q <= item.rx_byte - afr_pkg::DIGIT_BASE;
						write_position_q  <= 6'd0;
						phase_q           <= afr_pkg::PH_DATA;
					end
					afr_pkg::PH_DATA: begin
						if (write_position_q < DEPTH6) begin
							write_position_q  <= write_position_q + 6'd1;
							bytes_remaining_q <= br_dec;
							if (br_dec == 8'd0)
								phase_q <= afr_pkg::PH_CHECK;
						end else begin
							// overflow: drop the frame
							phase_q <= afr_pkg::PH_ADDRESS;
						end
					end
					afr_pkg::PH_CHECK: begin
						payload_count_q  <= write_position_q;
						delay_left_q     <= response_delay_q;
						frame_pending_q  <= 1'b1;
						phase_q          <= afr_pkg::PH_ADDRESS;
						write_position_q <= 6'd0;
					end
					default: phase_q <= afr_pkg::PH_ADDRESS;
				endcase
			end

			if (is_tick) begin
				delay_left_q <= dl_dec;
				if (dl_dec == 16'd0) begin
					frame_pending_q <= 1'b0;
					rd_index_q      <= 6'd0;
					if (payload_count_q != 6'd0)
						rel_state_q <= afr_pkg::REL_SEND;
				end
			end

			case (rel_state_q)
				afr_pkg::REL_IDLE: ;
				afr_pkg::REL_SEND: begin
					if (issue) begin
						rd_index_q <= rd_index_q + 6'd1;
						if (rd_last)
							rel_state_q <= afr_pkg::REL_IDLE;
					end
				end
				default: rel_state_q <= afr_pkg::REL_IDLE;
			endcase
		end
	end

	// reads only run while the input stalls, so they never meet a write
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[write_position_q[AW-1:0]] <= item.rx_byte;
		if (issue) begin
			rd_data_s1  <= mem[rd_index_q[AW-1:0]];
			rd_index_s1 <= rd_index_q;
			rd_last_s1  <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue)
				rd_valid_s1 <= 1'b1;
			else if (out_free)
				rd_valid_s1 <= 1'b0;

			if (out_free)
				out_valid_q <= rd_valid_s1 || mute_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (rd_valid_s1) begin
				out_data_q.kind         <= afr_pkg::KIND_DATA;
				out_data_q.payload_byte <= rd_data_s1;
				out_data_q.byte_index   <= rd_index_s1;
				out_data_q.last         <= rd_last_s1;
			end else if (mute_fire) begin
				out_data_q.kind         <= afr_pkg::KIND_MUTE;
				out_data_q.payload_byte <= 8'd0;
				out_data_q.byte_index   <= 6'd0;
				out_data_q.last         <= 1'b1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_data_q;

endmodule
